/* sv/grrp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the grid round-robin poller.
// No dependencies; imported by every module of the block.
package grrp_pkg;

	typedef enum logic [2:0] {
		OP_POLL     = 3'd0,
		OP_REPLY    = 3'd1,
		OP_ANNOUNCE = 3'd2,
		OP_RELEASE  = 3'd3,
		OP_RUN      = 3'd4,
		OP_IDLE     = 3'd5
	} op_t;

	typedef enum logic {
		KIND_TRACK  = 1'b0,
		KIND_NOTICE = 1'b1
	} kind_t;

	localparam logic [7:0] SWEEP_LIMIT_RESET = 8'd5;
	localparam int         S_TDATA_W         = 32;
	localparam int         M_TDATA_W         = 16;

	// One event as it sits in the input register.
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] reply_count;
		logic [7:0] grid_cols;
		logic [7:0] grid_rows;
	} item_t;

	// One result on its way to the output buffer.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] col;
		logic [7:0] row;
	} res_t;

endpackage

/* sv/grrp_in_stage.sv */
`timescale 1ns / 1ps
// Input register stage: unpacks the slave-side transfer into an event item.
// Depends on grrp_pkg.
module grrp_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [grrp_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          adv,
	output logic                          valid_s1,
	output grrp_pkg::item_t               item_s1
);
	import grrp_pkg::*;

	logic accept;

	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op          <= s_tdata[2:0];
			item_s1.reply_count <= s_tdata[10:3];
			item_s1.grid_cols   <= s_tdata[18:11];
			item_s1.grid_rows   <= s_tdata[26:19];
		end
	end

endmodule

/* sv/grrp_ctrl.sv */
`timescale 1ns / 1ps
// Poller state and event decode: one event per cycle while fire is high, at most one result.
// Depends on grrp_pkg.
module grrp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	input  logic            fire,
	input  grrp_pkg::item_t item,
	output logic            res_valid,
	output grrp_pkg::res_t  res
);
	import grrp_pkg::*;

	logic [7:0] sweep_lim_q;
	logic       running_q, waiting_q;
	logic [7:0] rx_q, exp_q, cur_col_q, cur_row_q, last_col_q, last_row_q, sweep_q;

	logic       running_d, waiting_d;
	logic [7:0] rx_d, exp_d, cur_col_d, cur_row_d, last_col_d, last_row_d, sweep_d;
	logic       act, notice, step, wait_mid;

	always_comb begin
		running_d  = running_q;
		waiting_d  = waiting_q;
		rx_d       = rx_q;
		exp_d      = exp_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		last_col_d = last_col_q;
		last_row_d = last_row_q;
		sweep_d    = sweep_q;
		res_valid  = 1'b0;
		res        = '{kind: KIND_TRACK, col: 8'd0, row: 8'd0};
		act        = running_q && (rx_q >= exp_q);
		notice     = act && (cur_col_q == 8'd0) && (cur_row_q == 8'd0)
		             && (sweep_q >= sweep_lim_q);
		wait_mid   = notice || waiting_q;
		step       = act && !wait_mid;

		unique case (op_t'(item.op))
			OP_POLL: begin
				if (notice) begin
					sweep_d   = 8'd0;
					waiting_d = 1'b1;
					res_valid = 1'b1;
					res.kind  = KIND_NOTICE;
				end
				if (step) begin
					if (cur_col_q == last_col_q) begin
						cur_col_d = 8'd0;
						if (cur_row_q == last_row_q) begin
							cur_row_d = 8'd0;
							sweep_d   = sweep_q + 8'd1;
						end else begin
							cur_row_d = cur_row_q + 8'd1;
						end
					end else begin
						cur_col_d = cur_col_q + 8'd1;
					end
					exp_d     = 8'd1;
					rx_d      = 8'd0;
					res_valid = 1'b1;
					res       = '{kind: KIND_TRACK, col: cur_col_d, row: cur_row_d};
				end
			end
			OP_REPLY:    rx_d = rx_q + 8'd1;
			OP_ANNOUNCE: begin
				exp_d = item.reply_count + 8'd1;
				rx_d  = 8'd1;
			end
			OP_RELEASE:  waiting_d = 1'b0;
			OP_RUN: begin
				running_d  = 1'b1;
				waiting_d  = 1'b0;
				rx_d       = 8'd0;
				exp_d      = 8'd0;
				last_col_d = item.grid_cols - 8'd1;
				last_row_d = item.grid_rows - 8'd1;
				cur_col_d  = last_col_d;
				cur_row_d  = last_row_d;
			end
			OP_IDLE: begin
				running_d = 1'b0;
				waiting_d = 1'b0;
			end
			default: ;
		endcase

		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_lim_q <= SWEEP_LIMIT_RESET;
		end else if (cfg_we) begin
			sweep_lim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			waiting_q  <= 1'b0;
			rx_q       <= 8'd0;
			exp_q      <= 8'd0;
			cur_col_q  <= 8'd0;
			cur_row_q  <= 8'd0;
			last_col_q <= 8'd0;
			last_row_q <= 8'd0;
			sweep_q    <= 8'd0;
		end else if (fire) begin
			running_q  <= running_d;
			waiting_q  <= waiting_d;
			rx_q       <= rx_d;
			exp_q      <= exp_d;
			cur_col_q  <= cur_col_d;
			cur_row_q  <= cur_row_d;
			last_col_q <= last_col_d;
			last_row_q <= last_row_d;
			sweep_q    <= sweep_d;
		end
	end

	// Position never runs past the grid corner set by the last run command.
	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= last_col_q) else $error("column beyond grid");
	a_row_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= last_row_q) else $error("row beyond grid");
	a_notice_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_NOTICE) |=> (waiting_q && sweep_q == 8'd0))
		else $error("notice did not park the poller");

endmodule

/* sv/grrp_out_buf.sv */
`timescale 1ns / 1ps
// Two-entry result buffer driving the master-side stream; ready is registered.
// Depends on grrp_pkg.
module grrp_out_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  grrp_pkg::res_t                res,
	output logic                          space,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [grrp_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser
);
	import grrp_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	res_t       head;

	assign space    = (count_q != 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign head     = mem_q[rd_ptr_q];
	assign m_tdata  = {head.row, head.col};
	assign m_tuser  = head.kind;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space) else $error("result pushed into full buffer");

endmodule

/* sv/grid_round_robin_poller.sv */
`timescale 1ns / 1ps
// Top level of the grid round-robin poller.
// Depends on grrp_pkg, grrp_in_stage, grrp_ctrl and grrp_out_buf.
//
// The poller walks a grid of modules in raster order (column first, then row,
// each wrapping) and takes one event per slave-side transfer: poll pass,
// tracking reply, reply-count announce, host release, run (carrying the grid
// size) or idle. A poll pass acts once all expected replies are in: at the
// origin, after sweep_limit full sweeps, it emits a host notice (tuser = 1)
// and parks until released; otherwise it steps to the next module and emits a
// tracking request (tuser = 0) with its column and row. Op codes 6 and 7 are
// dropped. The block sustains one transfer per clock while the output buffer
// has room; an event is registered on entry, decoded combinationally, and its
// result is written into a two-entry output buffer that drives the master
// side. The input stalls only while that buffer is full. Write sweep_limit
// (reset value 5) only while the block is quiet.
module grid_round_robin_poller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: sweep_limit
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [2:0] op, [10:3] reply_count,
	                              // [18:11] grid_cols, [26:19] grid_rows
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] col, [15:8] row
	output logic        m_tuser   // [0] kind
);
	import grrp_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  adv;
	logic  space;
	logic  res_valid;
	res_t  res;

	// Advance the held event whenever the output buffer has room; the buffer
	// status is registered, so no combinational path runs from m_tready back
	// to s_tready.
	assign adv = valid_s1 && space;

	grrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Decode the event, update the poller state and form at most one result.
	grrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.fire      (adv),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold results until the master side takes the transfer.
	grrp_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
